// ----- hdl/dns_name_to_text_defines.svh -----
// Assertion macros shared by the DNS name-to-text RTL.
// Included by every module that carries concurrent assertions.
`ifndef DNS_NAME_TO_TEXT_DEFINES_SVH
`define DNS_NAME_TO_TEXT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DN2T_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dn2t assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DN2T_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dn2t assertion failed");

`endif

// ----- hdl/dn2t_pkg.sv -----
// Shared types, constants and helper functions for the DNS name-to-text block.
// Used by the front end, the command queue, the back end and the top level.
`default_nettype none

package dn2t_pkg;

    localparam int unsigned SIZE_W    = 12;
    localparam int unsigned LEN_W     = 11;
    localparam logic [SIZE_W-1:0] SIZE_CAP = 12'd2048;
    localparam logic [SIZE_W-1:0] DEST_SIZE_RESET = 12'd1024;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // What the back end must emit for one accepted byte.
    typedef enum logic [2:0] {
        CMD_CHAR,      // the byte as it is
        CMD_SPECIAL,   // backslash, then the byte
        CMD_ESCAPE,    // backslash and three decimal digits
        CMD_DOT,       // label separator
        CMD_END,       // NUL with the text length
        CMD_ROOT,      // '.' then NUL, length one
        CMD_FAIL       // overflow error end
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [7:0]        data;
        logic [LEN_W-1:0]  len;
    } cmd_t;

    typedef struct packed {
        logic [LEN_W-1:0] text_length;
        logic             name_ok;
        logic             name_done;
        logic             char_valid;
        logic [7:0]       out_char;
    } result_t;

    typedef enum logic [1:0] {
        BK_PLAIN,
        BK_SPECIAL,
        BK_ESCAPE
    } byte_kind_t;

    function automatic byte_kind_t classify(input logic [7:0] b);
        byte_kind_t k;
        if (b < 8'h21 || b > 8'h7E) begin
            k = BK_ESCAPE;
        end else if (b == 8'h22 || b == 8'h24 || b == 8'h2E || b == 8'h3B ||
                     b == 8'h40 || b == 8'h5C) begin
            k = BK_SPECIAL;
        end else begin
            k = BK_PLAIN;
        end
        return k;
    endfunction

    // Returns {ones, tens, hundreds} as ASCII digits.
    function automatic logic [23:0] dec_digits(input logic [7:0] b);
        logic [1:0]  h;
        logic [7:0]  r;
        logic [14:0] prod;
        logic [3:0]  t;
        logic [7:0]  o;
        if (b >= 8'd200) begin
            h = 2'd2;
        end else if (b >= 8'd100) begin
            h = 2'd1;
        end else begin
            h = 2'd0;
        end
        r    = b - 8'(h) * 8'd100;
        // r is below 100, so r * 205 / 2048 is exactly r / 10.
        prod = 15'(r[6:0]) * 15'd205;
        t    = prod[14:11];
        o    = r - 8'(t) * 8'd10;
        return {CH_ZERO + o, CH_ZERO + 8'(t), CH_ZERO + 8'(h)};
    endfunction

endpackage

`default_nettype wire

// ----- hdl/dn2t_fifo.sv -----
// Short command queue between the front end and the back end.
// Depends on dn2t_pkg for cmd_t and the queue depth.
`default_nettype none

`include "dns_name_to_text_defines.svh"

module dn2t_fifo
    import dn2t_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output cmd_t      pop_cmd,
    output logic      empty
);

    cmd_t                mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]    count_reg, count_next;

    assign full    = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    `DN2T_ASSERT_IMPL(a_no_overflow, aclk, aresetn, full, !push)
    `DN2T_ASSERT_IMPL(a_no_underflow, aclk, aresetn, empty, !pop)
    `DN2T_ASSERT_NEXT(a_push_not_empty, aclk, aresetn, push, !empty)

endmodule

`default_nettype wire

// ----- hdl/dn2t_front.sv -----
// Front end: accepts wire-format bytes, tracks the name parse state and the
// capacity, and queues at most one output command per byte. Depends on dn2t_pkg.
`default_nettype none

module dn2t_front
    import dn2t_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [SIZE_W-1:0] cfg_wr_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [7:0]        in_byte,
    input  wire logic              in_start,
    output logic                   push,
    output cmd_t                   push_cmd,
    input  wire logic              q_full
);

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_LEN,
        PH_LABEL,
        PH_DISCARD
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [7:0]        left_reg, left_next;
    logic [LEN_W-1:0]  count_reg, count_next;
    logic              first_reg, first_next;
    logic [SIZE_W-1:0] dest_reg;

    logic [SIZE_W-1:0] eff;
    phase_t            ph;
    logic [LEN_W-1:0]  cnt;
    logic              fst;
    byte_kind_t        bk;
    logic [2:0]        extra;
    logic              fits;
    logic              has_cmd;
    logic              accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && has_cmd;
    assign eff      = (dest_reg > SIZE_CAP) ? SIZE_CAP : dest_reg;
    assign bk       = classify(in_byte);

    always_comb begin
        ph  = in_start ? PH_FIRST : phase_reg;
        cnt = in_start ? '0 : count_reg;
        fst = in_start ? 1'b1 : first_reg;

        // Characters this byte needs beyond those already written.
        if (ph == PH_LABEL) begin
            case (bk)
                BK_PLAIN:   extra = 3'd1;
                BK_SPECIAL: extra = 3'd2;
                default:    extra = 3'd4;
            endcase
        end else begin
            extra = 3'd1;
        end
        // Room is left while written + needed stays below the capacity.
        fits = ({2'b00, cnt} + 13'(extra)) < {1'b0, eff};

        phase_next = ph;
        left_next  = in_start ? 8'd0 : left_reg;
        count_next = cnt;
        first_next = fst;
        has_cmd    = 1'b0;
        push_cmd   = '{kind: CMD_CHAR, data: in_byte, len: '0};

        unique case (ph) inside
            PH_FIRST, PH_LEN: begin
                if (in_byte == 8'd0) begin
                    has_cmd    = 1'b1;
                    phase_next = PH_FIRST;
                    count_next = '0;
                    first_next = 1'b1;
                    left_next  = 8'd0;
                    if (ph == PH_FIRST) begin
                        if (eff < 12'd2) begin
                            push_cmd.kind = CMD_FAIL;
                            phase_next    = PH_DISCARD;
                        end else begin
                            push_cmd.kind = CMD_ROOT;
                            push_cmd.len  = LEN_W'(1);
                        end
                    end else begin
                        push_cmd.kind = CMD_END;
                        push_cmd.len  = cnt;
                    end
                end else if (!fits) begin
                    has_cmd       = 1'b1;
                    push_cmd.kind = CMD_FAIL;
                    phase_next    = PH_DISCARD;
                    count_next    = '0;
                    first_next    = 1'b1;
                    left_next     = 8'd0;
                end else begin
                    if (!fst) begin
                        has_cmd       = 1'b1;
                        push_cmd.kind = CMD_DOT;
                        count_next    = cnt + 1'b1;
                    end
                    first_next = 1'b0;
                    left_next  = in_byte;
                    phase_next = PH_LABEL;
                end
            end
            PH_LABEL: begin
                has_cmd = 1'b1;
                if (!fits) begin
                    push_cmd.kind = CMD_FAIL;
                    phase_next    = PH_DISCARD;
                    count_next    = '0;
                    first_next    = 1'b1;
                    left_next     = 8'd0;
                end else begin
                    case (bk)
                        BK_PLAIN:   push_cmd.kind = CMD_CHAR;
                        BK_SPECIAL: push_cmd.kind = CMD_SPECIAL;
                        default:    push_cmd.kind = CMD_ESCAPE;
                    endcase
                    count_next = cnt + LEN_W'(extra);
                    left_next  = left_reg - 1'b1;
                    if (left_reg == 8'd1) begin
                        phase_next = PH_LEN;
                    end
                end
            end
            default: begin
                // Dropping bytes until the next name start.
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_FIRST;
            left_reg  <= 8'd0;
            count_reg <= '0;
            first_reg <= 1'b1;
        end else if (accept) begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            count_reg <= count_next;
            first_reg <= first_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dest_reg <= DEST_SIZE_RESET;
        end else if (cfg_wr_en) begin
            dest_reg <= cfg_wr_data;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/dn2t_back.sv -----
// Back end: takes commands from the queue and emits one text character per
// cycle into the output register while it is free. Depends on dn2t_pkg.
`default_nettype none

`include "dns_name_to_text_defines.svh"

module dn2t_back
    import dn2t_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic q_empty,
    input  wire cmd_t q_cmd,
    output logic      q_pop,
    output logic      out_valid,
    input  wire logic out_ready,
    output result_t   out_result,
    output logic      out_last
);

    cmd_t       cur_reg;
    logic       cur_valid_reg;
    logic [1:0] step_reg;
    result_t    res_reg;
    logic       last_reg;
    logic       valid_reg;

    logic [1:0]  final_step;
    logic        out_free;
    logic        emit;
    logic        done;
    logic [23:0] digits;
    result_t     res;

    assign out_valid  = valid_reg;
    assign out_result = res_reg;
    assign out_last   = last_reg;

    assign out_free = !valid_reg || out_ready;
    assign emit     = cur_valid_reg && out_free;
    assign done     = emit && (step_reg == final_step);
    assign q_pop    = !q_empty && (!cur_valid_reg || done);
    assign digits   = dec_digits(cur_reg.data);

    always_comb begin
        unique case (cur_reg.kind) inside
            CMD_SPECIAL, CMD_ROOT: final_step = 2'd1;
            CMD_ESCAPE:            final_step = 2'd3;
            default:               final_step = 2'd0;
        endcase
    end

    always_comb begin
        res = '{text_length: '0, name_ok: 1'b0, name_done: 1'b0,
                char_valid: 1'b1, out_char: cur_reg.data};
        unique case (cur_reg.kind)
            CMD_CHAR: begin
            end
            CMD_SPECIAL: begin
                if (step_reg == 2'd0) begin
                    res.out_char = CH_BSL;
                end
            end
            CMD_ESCAPE: begin
                case (step_reg)
                    2'd0:    res.out_char = CH_BSL;
                    2'd1:    res.out_char = digits[7:0];
                    2'd2:    res.out_char = digits[15:8];
                    default: res.out_char = digits[23:16];
                endcase
            end
            CMD_DOT: begin
                res.out_char = CH_DOT;
            end
            CMD_ROOT: begin
                if (step_reg == 2'd0) begin
                    res.out_char = CH_DOT;
                end else begin
                    res.out_char    = CH_NUL;
                    res.name_done   = 1'b1;
                    res.name_ok     = 1'b1;
                    res.text_length = cur_reg.len;
                end
            end
            CMD_END: begin
                res.out_char    = CH_NUL;
                res.name_done   = 1'b1;
                res.name_ok     = 1'b1;
                res.text_length = cur_reg.len;
            end
            default: begin
                res.out_char   = CH_NUL;
                res.char_valid = 1'b0;
                res.name_done  = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            step_reg      <= 2'd0;
            valid_reg     <= 1'b0;
        end else begin
            if (q_pop) begin
                cur_valid_reg <= 1'b1;
                step_reg      <= 2'd0;
            end else if (done) begin
                cur_valid_reg <= 1'b0;
            end else if (emit) begin
                step_reg <= step_reg + 1'b1;
            end
            if (emit) begin
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_cmd;
        end
        if (emit) begin
            res_reg  <= res;
            last_reg <= (step_reg == final_step);
        end
    end

    `DN2T_ASSERT_IMPL(a_done_is_last, aclk, aresetn,
        valid_reg && res_reg.name_done, last_reg)
    `DN2T_ASSERT_IMPL(a_error_shape, aclk, aresetn,
        valid_reg && !res_reg.char_valid,
        res_reg.name_done && !res_reg.name_ok && (res_reg.text_length == '0))

endmodule

`default_nettype wire

// ----- hdl/dns_name_to_text.sv -----
// Top level of the DNS wire-format name to presentation text converter.
// Instantiates dn2t_front, dn2t_fifo and dn2t_back; depends on dn2t_pkg.
`default_nettype none

// The block takes a wire-format domain name one byte per transfer on the
// s_ channel (tuser marks the first length byte of a new name) and delivers
// the presentation text one character per transfer on the m_ channel, with a
// done/ok/length report on the terminating NUL or on an overflow error, and
// tlast on the final character caused by each input byte. Each input byte
// is classified combinationally and queued as a command in a four-entry
// queue, so a new byte can be accepted every cycle while the queue has
// room. The output register emits one character per cycle unless m_tready
// stalls it: a byte yields one to four characters (plain character one,
// special two, decimal escape four, bytes with no text none). dest_size
// is written through cfg_wr_en/cfg_wr_data and resets to 1024.
module dns_name_to_text
    import dn2t_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [SIZE_W-1:0] cfg_wr_data,   // dest_size
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,       // [7:0] wire_byte
    input  wire logic              s_tuser,       // [0] name_start
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // [7:0] out_char, [8] char_valid, [9] name_done, [10] name_ok,
    // [21:11] text_length, [23:22] zero
    output logic [23:0]            m_tdata,
    output logic                   m_tlast
);

    logic    push;
    cmd_t    push_cmd;
    logic    q_full;
    logic    q_empty;
    logic    q_pop;
    cmd_t    q_cmd;
    result_t result;

    dn2t_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_byte     (s_tdata),
        .in_start    (s_tuser),
        .push        (push),
        .push_cmd    (push_cmd),
        .q_full      (q_full)
    );

    dn2t_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (q_cmd),
        .empty    (q_empty)
    );

    dn2t_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_empty),
        .q_cmd      (q_cmd),
        .q_pop      (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result),
        .out_last   (m_tlast)
    );

    assign m_tdata = {2'b00, result};

endmodule

`default_nettype wire
